// File: design/rspb_pkg.sv
// Shared types and constants for the range sensor pose box.
`default_nettype none

package rspb_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_W = 32;
	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

	// arctangent of 2^-i in 2^32-per-turn units
	localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10692126,  32'sd5348437,
		32'sd2674259,   32'sd1337135,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
	};

	localparam int TRIG_W = 16;
	localparam int TRIG_MAX = 32767;

	localparam int FIELD_W = 20;
	localparam int BOX_W = 17;
	localparam int SLACK_W = 21;
	localparam int LOC_W = 16;
	localparam int BOX_MAX = 131071;
	localparam int LOC_MAX = 65535;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT = 2'd1;
	localparam logic [FIELD_W-1:0] FIELD_WIDTH_RESET = 20'd800;
	localparam logic [FIELD_W-1:0] FIELD_HEIGHT_RESET = 20'd1600;

	// quadrant of the heading plus the sensor's quarter turns
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
	} cordic_vec_t;

endpackage

`default_nettype wire

// File: design/rspb_cordic_cell.sv
// One CORDIC rotation cell; carries the sensor payload along the chain.
`default_nettype none

module rspb_cordic_cell #(
	parameter int STEP = 0,
	parameter int PAY_W = 66
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire rspb_pkg::cordic_vec_t in_vec,
	input  wire logic [PAY_W-1:0]    in_pay,
	output logic                     out_valid,
	output rspb_pkg::cordic_vec_t    out_vec,
	output logic [PAY_W-1:0]         out_pay
);

	logic signed [rspb_pkg::CORDIC_W-1:0] dx;
	logic signed [rspb_pkg::CORDIC_W-1:0] dy;
	logic signed [rspb_pkg::CORDIC_W-1:0] atan_c;
	rspb_pkg::cordic_vec_t next_vec;

	assign dx = $signed(in_vec.y) >>> STEP;
	assign dy = $signed(in_vec.x) >>> STEP;
	assign atan_c = rspb_pkg::ATAN_TURNS[4'(STEP)];

	always_comb begin
		if (!in_vec.z[rspb_pkg::CORDIC_W-1]) begin
			next_vec.x = in_vec.x - dx;
			next_vec.y = in_vec.y + dy;
			next_vec.z = in_vec.z - atan_c;
		end else begin
			next_vec.x = in_vec.x + dx;
			next_vec.y = in_vec.y - dy;
			next_vec.z = in_vec.z + atan_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec <= next_vec;
			out_pay <= in_pay;
		end
	end

endmodule

`default_nettype wire

// File: design/rspb_box.sv
// Projection of the four readings, min/max tracking and box/slack/location output.
`default_nettype none

module rspb_box #(
	parameter int RANGE_BITS = 16,
	parameter int PAY_W = 4 * RANGE_BITS + 2
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic                                in_valid,
	input  wire rspb_pkg::cordic_vec_t               in_vec,
	input  wire logic [PAY_W-1:0]                    in_pay,
	input  wire logic [rspb_pkg::FIELD_W-1:0]        field_width,
	input  wire logic [rspb_pkg::FIELD_W-1:0]        field_height,
	output logic                                     out_valid,
	output logic [rspb_pkg::BOX_W-1:0]               box_width,
	output logic [rspb_pkg::BOX_W-1:0]               box_height,
	output logic signed [rspb_pkg::SLACK_W-1:0]      slack_width,
	output logic signed [rspb_pkg::SLACK_W-1:0]      slack_height,
	output logic [rspb_pkg::LOC_W-1:0]               loc_x,
	output logic [rspb_pkg::LOC_W-1:0]               loc_y
);

	localparam int TW = rspb_pkg::TRIG_W;
	localparam int CWD = rspb_pkg::CORDIC_W;
	localparam int PW = RANGE_BITS + 17;       // product width
	localparam int CW = RANGE_BITS + 3;        // coordinate width
	localparam int EXT = (CW + 1 > 22) ? CW + 1 : 22;

	// stage 1: sine/cosine rounding and per-sensor quadrant selection
	logic signed [CWD:0] xr;
	logic signed [CWD:0] yr;
	logic signed [CWD-15:0] xsh;
	logic signed [CWD-15:0] ysh;
	logic signed [TW-1:0] cos_v;
	logic signed [TW-1:0] sin_v;
	logic [1:0] quad;
	logic signed [TW-1:0] cm [4];
	logic signed [TW-1:0] sm [4];

	logic                  valid_s1;
	logic [RANGE_BITS-1:0] mag_s1 [4];
	logic signed [TW-1:0]  cm_s1 [4];
	logic signed [TW-1:0]  sm_s1 [4];

	function automatic logic signed [TW-1:0] clamp_q15(input logic signed [CWD-15:0] v);
		logic signed [CWD-15:0] lim;
		lim = (CWD - 14)'(rspb_pkg::TRIG_MAX);
		if (v > lim)
			return TW'(rspb_pkg::TRIG_MAX);
		else if (v < -lim)
			return -TW'(rspb_pkg::TRIG_MAX);
		else
			return v[TW-1:0];
	endfunction

	assign xr = {in_vec.x[CWD-1], in_vec.x} + (CWD + 1)'(16384);
	assign yr = {in_vec.y[CWD-1], in_vec.y} + (CWD + 1)'(16384);
	assign xsh = xr[CWD:15];
	assign ysh = yr[CWD:15];
	assign cos_v = clamp_q15(xsh);
	assign sin_v = clamp_q15(ysh);
	assign quad = in_pay[PAY_W-1 -: 2];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			case (quad + 2'(k))
				rspb_pkg::QUAD_0: begin
					cm[k] = cos_v;
					sm[k] = sin_v;
				end
				rspb_pkg::QUAD_1: begin
					cm[k] = -sin_v;
					sm[k] = cos_v;
				end
				rspb_pkg::QUAD_2: begin
					cm[k] = -cos_v;
					sm[k] = -sin_v;
				end
				default: begin
					cm[k] = sin_v;
					sm[k] = -cos_v;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				mag_s1[k] <= in_pay[k*RANGE_BITS +: RANGE_BITS];
				cm_s1[k] <= cm[k];
				sm_s1[k] <= sm[k];
			end
		end
	end

	// stage 2: products
	logic                 valid_s2;
	logic signed [PW-1:0] px_s2 [4];
	logic signed [PW-1:0] py_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				px_s2[k] <= $signed({1'b0, mag_s1[k]}) * cm_s1[k];
				py_s2[k] <= $signed({1'b0, mag_s1[k]}) * sm_s1[k];
			end
		end
	end

	// stage 3: round to signed Q19.0 integers and track extents from zero
	logic signed [PW:0]   rx [4];
	logic signed [PW:0]   ry [4];
	logic signed [CW-1:0] cx [4];
	logic signed [CW-1:0] cy [4];
	logic signed [CW-1:0] xmin;
	logic signed [CW-1:0] xmax;
	logic signed [CW-1:0] ymin;
	logic signed [CW-1:0] ymax;

	logic                 valid_s3;
	logic signed [CW-1:0] xmin_s3;
	logic signed [CW-1:0] xmax_s3;
	logic signed [CW-1:0] ymin_s3;
	logic signed [CW-1:0] ymax_s3;

	always_comb begin
		xmin = '0;
		xmax = '0;
		ymin = '0;
		ymax = '0;
		for (int k = 0; k < 4; k++) begin
			rx[k] = {px_s2[k][PW-1], px_s2[k]} + (PW + 1)'(16384);
			ry[k] = {py_s2[k][PW-1], py_s2[k]} + (PW + 1)'(16384);
			cx[k] = rx[k][PW:15];
			cy[k] = ry[k][PW:15];
			if (cx[k] > xmax) xmax = cx[k];
			if (cx[k] < xmin) xmin = cx[k];
			if (cy[k] > ymax) ymax = cy[k];
			if (cy[k] < ymin) ymin = cy[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xmin_s3 <= xmin;
			xmax_s3 <= xmax;
			ymin_s3 <= ymin;
			ymax_s3 <= ymax;
		end
	end

	// stage 4: box, location, slack into the output register
	logic [CW:0]                bw;
	logic [CW:0]                bh;
	logic [CW:0]                nx;
	logic [CW:0]                ny;
	logic [EXT-1:0]             bw_e;
	logic [EXT-1:0]             bh_e;
	logic [EXT-1:0]             nx_e;
	logic [EXT-1:0]             ny_e;
	logic [rspb_pkg::BOX_W-1:0] bw_sat;
	logic [rspb_pkg::BOX_W-1:0] bh_sat;

	// extents hold max >= 0 >= min, so the differences are non-negative
	assign bw = {xmax_s3[CW-1], xmax_s3} - {xmin_s3[CW-1], xmin_s3};
	assign bh = {ymax_s3[CW-1], ymax_s3} - {ymin_s3[CW-1], ymin_s3};
	assign nx = -{xmin_s3[CW-1], xmin_s3};
	assign ny = -{ymin_s3[CW-1], ymin_s3};
	assign bw_e = EXT'(bw);
	assign bh_e = EXT'(bh);
	assign nx_e = EXT'(nx);
	assign ny_e = EXT'(ny);
	assign bw_sat = (bw_e > EXT'(rspb_pkg::BOX_MAX)) ? rspb_pkg::BOX_W'(rspb_pkg::BOX_MAX)
		: bw_e[rspb_pkg::BOX_W-1:0];
	assign bh_sat = (bh_e > EXT'(rspb_pkg::BOX_MAX)) ? rspb_pkg::BOX_W'(rspb_pkg::BOX_MAX)
		: bh_e[rspb_pkg::BOX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			box_width <= bw_sat;
			box_height <= bh_sat;
			slack_width <= $signed({1'b0, field_width}) - $signed({4'b0, bw_sat});
			slack_height <= $signed({1'b0, field_height}) - $signed({4'b0, bh_sat});
			loc_x <= (nx_e > EXT'(rspb_pkg::LOC_MAX)) ? rspb_pkg::LOC_W'(rspb_pkg::LOC_MAX)
				: nx_e[rspb_pkg::LOC_W-1:0];
			loc_y <= (ny_e > EXT'(rspb_pkg::LOC_MAX)) ? rspb_pkg::LOC_W'(rspb_pkg::LOC_MAX)
				: ny_e[rspb_pkg::LOC_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: design/range_sensor_pose_box_unit.sv
// Top level: CORDIC cell chain feeding the box/pose stages, plus field size registers.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------------
//  in       | in_valid / in_stall  | range_right/forward/left/back, heading
//  out      | out_valid / out_stall| box_width/height, slack_width/height, loc_x/y
//  cfg      | cfg_we               | cfg_index, cfg_data (field_width, field_height)
//
// One item per cycle while out_stall does not hold the pipeline; the path is 16 CORDIC
// cells, then projection, multiply, min/max and the output register.
// The whole pipeline holds while out_valid is high and out_stall is high; in_stall
// follows that condition, so items behind a waiting result keep their place.
// Reset clears the valid bits and loads field_width 800 and field_height 1600.
`default_nettype none

module range_sensor_pose_box_unit #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [rspb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rspb_pkg::FIELD_W-1:0]         cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [15:0]                          range_right,
	input  wire logic [15:0]                          range_forward,
	input  wire logic [15:0]                          range_left,
	input  wire logic [15:0]                          range_back,
	input  wire logic [15:0]                          heading,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [rspb_pkg::BOX_W-1:0]                box_width,
	output logic [rspb_pkg::BOX_W-1:0]                box_height,
	output logic signed [rspb_pkg::SLACK_W-1:0]       slack_width,
	output logic signed [rspb_pkg::SLACK_W-1:0]       slack_height,
	output logic [rspb_pkg::LOC_W-1:0]                loc_x,
	output logic [rspb_pkg::LOC_W-1:0]                loc_y
);

	localparam int PAY_W = 4 * RANGE_BITS + 2;
	localparam int NC = rspb_pkg::CORDIC_STEPS;
	localparam int CWD = rspb_pkg::CORDIC_W;

	logic [rspb_pkg::FIELD_W-1:0] field_width_q;
	logic [rspb_pkg::FIELD_W-1:0] field_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= rspb_pkg::FIELD_WIDTH_RESET;
			field_height_q <= rspb_pkg::FIELD_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rspb_pkg::REG_FIELD_WIDTH: field_width_q <= cfg_data;
				rspb_pkg::REG_FIELD_HEIGHT: field_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [CWD-1:0]        turn;
	logic [ANGLE_BITS-1:0] ang;
	assign ang = ANGLE_BITS'(heading);
	assign turn = CWD'(ang) << (CWD - ANGLE_BITS);

	logic                  chain_valid [NC+1];
	rspb_pkg::cordic_vec_t chain_vec [NC+1];
	logic [PAY_W-1:0]      chain_pay [NC+1];

	assign chain_valid[0] = in_valid;
	assign chain_vec[0].x = rspb_pkg::CORDIC_X0;
	assign chain_vec[0].y = '0;
	assign chain_vec[0].z = $signed({2'b00, turn[CWD-3:0]});
	assign chain_pay[0] = {turn[CWD-1:CWD-2],
		RANGE_BITS'(range_back), RANGE_BITS'(range_left),
		RANGE_BITS'(range_forward), RANGE_BITS'(range_right)};

	for (genvar i = 0; i < NC; i++) begin : g_cell
		rspb_cordic_cell #(
			.STEP (i),
			.PAY_W(PAY_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (chain_valid[i]),
			.in_vec   (chain_vec[i]),
			.in_pay   (chain_pay[i]),
			.out_valid(chain_valid[i+1]),
			.out_vec  (chain_vec[i+1]),
			.out_pay  (chain_pay[i+1])
		);
	end

	rspb_box #(
		.RANGE_BITS(RANGE_BITS),
		.PAY_W     (PAY_W)
	) u_box (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (chain_valid[NC]),
		.in_vec      (chain_vec[NC]),
		.in_pay      (chain_pay[NC]),
		.field_width (field_width_q),
		.field_height(field_height_q),
		.out_valid   (out_valid),
		.box_width   (box_width),
		.box_height  (box_height),
		.slack_width (slack_width),
		.slack_height(slack_height),
		.loc_x       (loc_x),
		.loc_y       (loc_y)
	);

endmodule

`default_nettype wire
